[rtl/core/rc4_pkg.sv]
// rc4_pkg: shared types and constants for the RC4 stream cipher block.
// Item structs, command and status codes, sequencer states, engine handshake.
// No dependencies.
package rc4_pkg;

    localparam int PERM_SIZE = 256;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = $clog2(PERM_SIZE);
    localparam int KLEN_W    = 9;

    localparam logic [KLEN_W-1:0] KEY_LENGTH_RESET = 9'd64;
    localparam logic [KLEN_W-1:0] KEY_LENGTH_MAX   = 9'd256;

    localparam logic [1:0] CMD_KEY_WRITE = 2'd0;
    localparam logic [1:0] CMD_SCHEDULE  = 2'd1;
    localparam logic [1:0] CMD_CIPHER    = 2'd2;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_KEYED = 1'b1;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] key_index;
        logic [BYTE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              status;
    } t_out;

    typedef struct packed {
        logic start;
        logic take;
        t_in  item;
    } t_eng_req;

    typedef struct packed {
        logic busy;
        logic res_valid;
        t_out res;
    } t_eng_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD,
        ST_KS_ACC,
        ST_KS_WR_N,
        ST_KS_WR_A,
        ST_CI_RD_I,
        ST_CI_J,
        ST_CI_WR_I,
        ST_CI_WR_J,
        ST_CI_RD_K,
        ST_CI_KEY,
        ST_RESULT
    } t_state;

endpackage

[rtl/core/rc4_stream_cipher.sv]
// rc4_stream_cipher: RC4 top level. A key write goes straight to the key store. A data byte steps
// through read S[i], update j, write S[i], write S[j], read S[i]+S[j] and XOR, on the one-read,
// one-write permutation RAM. A not-keyed data byte goes straight to the result. A schedule fills S,
// then swaps (read, accumulate, two writes). Input stalled while the engine is busy or in reset.
// Sync active-low reset clears i, j, keyed flag, key_length (to 64) and output valid; RAM contents are not cleared.
module rc4_stream_cipher (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  rc4_pkg::t_in               i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output rc4_pkg::t_out              o_out_item,
    input  logic                       i_cfg_we,
    input  logic [rc4_pkg::KLEN_W-1:0] i_cfg_data
);

    logic [rc4_pkg::KLEN_W-1:0] r_key_length;
    logic                       r_out_valid, n_out_valid;
    rc4_pkg::t_out              r_out_item;

    rc4_pkg::t_eng_req eng_req;
    rc4_pkg::t_eng_rsp eng_rsp;
    logic              in_accept;
    logic              res_take;

    assign o_in_stall = eng_rsp.busy || !i_rst_n;
    assign in_accept  = i_in_valid && !o_in_stall;
    // output register frees up when empty or being drained this cycle
    assign res_take   = eng_rsp.res_valid && (!r_out_valid || !i_out_stall);

    assign eng_req.start = in_accept;
    assign eng_req.take  = res_take;
    assign eng_req.item  = i_in_item;

    rc4_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (eng_req),
        .i_key_length(r_key_length),
        .o_rsp       (eng_rsp)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_take) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= rc4_pkg::KEY_LENGTH_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_key_length <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_item <= eng_rsp.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_res_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_rsp.res_valid |-> o_in_stall)
        else $error("engine result pending while input is open");

    a_not_keyed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == rc4_pkg::STATUS_NOT_KEYED))
        |-> (o_out_item.data_out == '0))
        else $error("not-keyed result carries nonzero data");

    a_cipher_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_item.command == rc4_pkg::CMD_CIPHER)) |=> o_in_stall)
        else $error("data item did not occupy the engine");

    a_schedule_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_item.command == rc4_pkg::CMD_SCHEDULE))
        |=> (o_in_stall && !eng_rsp.res_valid))
        else $error("schedule item did not start the sequencer");

endmodule

[rtl/core/rc4_ram.sv]
// rc4_ram: generic one-write, one-read RAM with registered read data.
// Standalone; no package dependency.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/rc4_engine.sv]
// rc4_engine: sequencer, index registers and shared byte adder for RC4.
// Holds the permutation and key store in two rc4_ram instances.
// Depends on rc4_pkg and rc4_ram.
module rc4_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rc4_pkg::t_eng_req             i_req,
    input  logic [rc4_pkg::KLEN_W-1:0]    i_key_length,
    output rc4_pkg::t_eng_rsp             o_rsp
);

    rc4_pkg::t_state r_state, n_state;

    logic [rc4_pkg::ADDR_W-1:0] r_n,    n_n;
    logic [rc4_pkg::ADDR_W-1:0] r_kidx, n_kidx;
    logic [rc4_pkg::BYTE_W-1:0] r_acc,  n_acc;
    logic [rc4_pkg::ADDR_W-1:0] r_i,    n_i;
    logic [rc4_pkg::ADDR_W-1:0] r_j,    n_j;
    logic                       r_keyed, n_keyed;
    logic [rc4_pkg::BYTE_W-1:0] r_si,   n_si;
    logic [rc4_pkg::BYTE_W-1:0] r_sj,   n_sj;
    logic [rc4_pkg::BYTE_W-1:0] r_data, n_data;
    rc4_pkg::t_out              r_res,  n_res;

    // shared byte adder
    logic [rc4_pkg::BYTE_W-1:0] add_a, add_b, add_c, add_sum;

    logic                       perm_we;
    logic [rc4_pkg::ADDR_W-1:0] perm_waddr, perm_raddr;
    logic [rc4_pkg::BYTE_W-1:0] perm_wdata, perm_rdata;

    logic                       key_we;
    logic [rc4_pkg::BYTE_W-1:0] key_rdata;

    logic [rc4_pkg::KLEN_W-1:0] eff_len;
    logic                       kidx_wrap;

    rc4_ram #(.WIDTH(rc4_pkg::BYTE_W), .DEPTH(rc4_pkg::PERM_SIZE)) u_perm (
        .i_clk  (i_clk),
        .i_we   (perm_we),
        .i_waddr(perm_waddr),
        .i_wdata(perm_wdata),
        .i_raddr(perm_raddr),
        .o_rdata(perm_rdata)
    );

    rc4_ram #(.WIDTH(rc4_pkg::BYTE_W), .DEPTH(rc4_pkg::PERM_SIZE)) u_key (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(i_req.item.key_index),
        .i_wdata(i_req.item.value),
        .i_raddr(r_kidx),
        .o_rdata(key_rdata)
    );

    assign key_we = (r_state == rc4_pkg::ST_IDLE) && i_req.start
                    && (i_req.item.command == rc4_pkg::CMD_KEY_WRITE);

    // zero or anything above 256 means a full 256-byte key
    assign eff_len = ((i_key_length == '0) || (i_key_length > rc4_pkg::KEY_LENGTH_MAX))
                     ? rc4_pkg::KEY_LENGTH_MAX : i_key_length;
    assign kidx_wrap = (({1'b0, r_kidx} + 9'd1) == eff_len);

    assign add_sum = add_a + add_b + add_c;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_kidx  = r_kidx;
        n_acc   = r_acc;
        n_i     = r_i;
        n_j     = r_j;
        n_keyed = r_keyed;
        n_si    = r_si;
        n_sj    = r_sj;
        n_data  = r_data;
        n_res   = r_res;

        add_a = r_acc;
        add_b = perm_rdata;
        add_c = '0;

        perm_we    = 1'b0;
        perm_waddr = r_n;
        perm_wdata = r_n;
        perm_raddr = r_n;

        case (r_state)
            rc4_pkg::ST_IDLE: begin
                if (i_req.start) begin
                    case (i_req.item.command)
                        rc4_pkg::CMD_SCHEDULE: begin
                            n_n     = '0;
                            n_state = rc4_pkg::ST_FILL;
                        end
                        rc4_pkg::CMD_CIPHER: begin
                            if (r_keyed) begin
                                n_i     = r_i + 8'd1;
                                n_data  = i_req.item.value;
                                n_state = rc4_pkg::ST_CI_RD_I;
                            end else begin
                                n_res.data_out = '0;
                                n_res.status   = rc4_pkg::STATUS_NOT_KEYED;
                                n_state        = rc4_pkg::ST_RESULT;
                            end
                        end
                        default: begin
                            // key writes go straight to the key store; code 3 is dropped
                        end
                    endcase
                end
            end
            rc4_pkg::ST_FILL: begin
                perm_we    = 1'b1;
                perm_waddr = r_n;
                perm_wdata = r_n;
                n_n        = r_n + 8'd1;
                if (r_n == 8'hFF) begin
                    n_acc   = '0;
                    n_kidx  = '0;
                    n_state = rc4_pkg::ST_KS_RD;
                end
            end
            rc4_pkg::ST_KS_RD: begin
                perm_raddr = r_n;
                n_state    = rc4_pkg::ST_KS_ACC;
            end
            rc4_pkg::ST_KS_ACC: begin
                add_a      = r_acc;
                add_b      = perm_rdata;
                add_c      = key_rdata;
                n_acc      = add_sum;
                n_si       = perm_rdata;
                perm_raddr = add_sum;
                n_state    = rc4_pkg::ST_KS_WR_N;
            end
            rc4_pkg::ST_KS_WR_N: begin
                perm_we    = 1'b1;
                perm_waddr = r_n;
                perm_wdata = perm_rdata;
                n_state    = rc4_pkg::ST_KS_WR_A;
            end
            rc4_pkg::ST_KS_WR_A: begin
                perm_we    = 1'b1;
                perm_waddr = r_acc;
                perm_wdata = r_si;
                n_n        = r_n + 8'd1;
                n_kidx     = kidx_wrap ? '0 : r_kidx + 8'd1;
                if (r_n == 8'hFF) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_keyed = 1'b1;
                    n_state = rc4_pkg::ST_IDLE;
                end else begin
                    n_state = rc4_pkg::ST_KS_RD;
                end
            end
            rc4_pkg::ST_CI_RD_I: begin
                perm_raddr = r_i;
                n_state    = rc4_pkg::ST_CI_J;
            end
            rc4_pkg::ST_CI_J: begin
                add_a      = r_j;
                add_b      = perm_rdata;
                add_c      = '0;
                n_j        = add_sum;
                n_si       = perm_rdata;
                perm_raddr = add_sum;
                n_state    = rc4_pkg::ST_CI_WR_I;
            end
            rc4_pkg::ST_CI_WR_I: begin
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = perm_rdata;
                n_sj       = perm_rdata;
                n_state    = rc4_pkg::ST_CI_WR_J;
            end
            rc4_pkg::ST_CI_WR_J: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
                n_state    = rc4_pkg::ST_CI_RD_K;
            end
            rc4_pkg::ST_CI_RD_K: begin
                // both writes have landed, so S[i] + S[j] is si + sj
                add_a      = r_si;
                add_b      = r_sj;
                add_c      = '0;
                perm_raddr = add_sum;
                n_state    = rc4_pkg::ST_CI_KEY;
            end
            rc4_pkg::ST_CI_KEY: begin
                n_res.data_out = r_data ^ perm_rdata;
                n_res.status   = rc4_pkg::STATUS_OK;
                n_state        = rc4_pkg::ST_RESULT;
            end
            rc4_pkg::ST_RESULT: begin
                if (i_req.take) begin
                    n_state = rc4_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rc4_pkg::ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_keyed <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_keyed <= n_keyed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_kidx <= n_kidx;
        r_acc  <= n_acc;
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_data <= n_data;
        r_res  <= n_res;
    end

    assign o_rsp.busy      = (r_state != rc4_pkg::ST_IDLE);
    assign o_rsp.res_valid = (r_state == rc4_pkg::ST_RESULT);
    assign o_rsp.res       = r_res;

endmodule
